@@ rtl/vtc_pkg.sv @@
// ----------------------------------------------------------------------------
// vtc_pkg
// Shared types and constants of the vario tone controller.
// ----------------------------------------------------------------------------
package vtc_pkg;

  // Timer clock: bus clock, possibly doubled.
  localparam int unsigned BusClkW   = 28;
  localparam int unsigned ClkW      = BusClkW + 1;
  // Prescaled divisor (p+1)*freq fits in 16+12 bits.
  localparam int unsigned FreqW     = 12;
  localparam int unsigned DivisorW  = 28;
  localparam int unsigned DivCntW   = $clog2(ClkW + 1);
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned TimW      = 16;

  localparam logic [CfgIdxW-1:0] CfgBusClock     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBusPrescaled = CfgIdxW'(1);

  localparam logic [BusClkW-1:0] BusClockReset = BusClkW'(72000000);

  localparam logic [TimW-1:0] PrescLast = 16'hFFFE;
  localparam logic [TimW-1:0] PrescCap  = 16'hFFFF;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic                start;
    logic [ClkW-1:0]     dividend;
    logic [DivisorW-1:0] divisor;
  } div_req_t;

  // Status back from the divider.
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [ClkW-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/vtc_div.sv @@
// ----------------------------------------------------------------------------
// vtc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vtc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vtc_pkg::div_req_t req_i,
  output vtc_pkg::div_rsp_t rsp_o
);

  logic [vtc_pkg::ClkW-1:0]     dvd_q, dvd_d;
  logic [vtc_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [vtc_pkg::DivisorW-1:0] dsr_q, dsr_d;
  logic [vtc_pkg::DivCntW-1:0]  cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;

  logic [vtc_pkg::DivisorW:0]   shifted;
  logic [vtc_pkg::DivisorW:0]   trial;
  logic                         qbit;

  always_comb begin
    shifted = {rem_q, dvd_q[vtc_pkg::ClkW-1]};
    trial   = shifted - {1'b0, dsr_q};
    qbit    = !trial[vtc_pkg::DivisorW];
  end

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = vtc_pkg::DivCntW'(vtc_pkg::ClkW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = qbit ? trial[vtc_pkg::DivisorW-1:0] : shifted[vtc_pkg::DivisorW-1:0];
      dvd_d = {dvd_q[vtc_pkg::ClkW-2:0], qbit};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

`ifndef NO_ASSERTIONS
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q != '0 |=> busy_q && cnt_q == $past(cnt_q) - 1'b1)
    else $error("divider step count skipped");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start && cnt_q == '0 |=> done_q)
    else $error("divider missed its done pulse");
`endif

endmodule

@@ rtl/vario_tone_controller_core.sv @@
// ----------------------------------------------------------------------------
// vario_tone_controller_core
// Climb-rate to tone timer control with prescaler search and period divide.
// ----------------------------------------------------------------------------
// Steps: a word with no timer start goes from idle to the finish state and
// then into the output register; a start runs the prescaler search, then the
// divider, then the finish state, before it reaches the output register.
// Throughput: one word at a time; the next word is taken once the result is
// in the output register. Reset: tone off, last change time 0, 72 MHz bus.
// ----------------------------------------------------------------------------
module vario_tone_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vtc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [vtc_pkg::BusClkW-1:0]       cfg_data_i,
  // input words
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [15:0]                climb_rate_i,
  input  logic [31:0]                       now_ms_i,
  // result words
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              tone_on_o,
  output logic                              timer_write_o,
  output logic [vtc_pkg::TimW-1:0]          prescale_value_o,
  output logic [vtc_pkg::TimW-1:0]          reload_value_o,
  output logic [vtc_pkg::TimW-1:0]          compare_value_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StDivide,
    StFinish
  } state_e;

  typedef enum logic [1:0] {
    ActNone,
    ActStart,
    ActStop
  } action_e;

  // configuration registers
  logic [vtc_pkg::BusClkW-1:0] bus_clock_q;
  logic                        bus_prescaled_q;
  logic [vtc_pkg::ClkW-1:0]    clk_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_clock_q     <= vtc_pkg::BusClockReset;
      bus_prescaled_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        vtc_pkg::CfgBusClock:     bus_clock_q     <= cfg_data_i;
        vtc_pkg::CfgBusPrescaled: bus_prescaled_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign clk_eff = bus_prescaled_q ? {bus_clock_q, 1'b0} : {1'b0, bus_clock_q};

  // ---------------------------------------------------------------- decode
  state_e                      state_q;
  logic                        beep_active_q;
  logic [31:0]                 last_change_q;

  logic                        is_dead, is_climb, is_sink;
  logic [5:0]                  climb_c;
  logic [16:0]                 sink_mag;
  logic [5:0]                  sink_c;
  logic [vtc_pkg::FreqW-1:0]   freq_climb, freq_sink, freq_sel;
  logic [7:0]                  beep_raw, beep_ms;
  logic [8:0]                  pause_raw, pause_ms;
  logic [31:0]                 elapsed;
  action_e                     action;

  always_comb begin
    is_dead  = (climb_rate_i >= -16'sd1) && (climb_rate_i <= 16'sd1);
    is_climb = climb_rate_i >= 16'sd2;
    is_sink  = climb_rate_i <= -16'sd10;

    // clamp climb to 50
    climb_c = (climb_rate_i > 16'sd50) ? 6'd50 : climb_rate_i[5:0];
    freq_climb = vtc_pkg::FreqW'(12'd1200 + 12'(climb_c) * 12'd40);
    if (freq_climb > 12'd3200) begin
      freq_climb = 12'd3200;
    end
    beep_raw  = 8'd140 - 8'(climb_c) * 8'd2;
    beep_ms   = (beep_raw < 8'd40) ? 8'd40 : beep_raw;
    pause_raw = 9'd300 - 9'(climb_c) * 9'd4;
    pause_ms  = (pause_raw < 9'd60) ? 9'd60 : pause_raw;

    // clamp sink magnitude to 50
    sink_mag  = 17'd0 - {climb_rate_i[15], climb_rate_i};
    sink_c    = (sink_mag > 17'd50) ? 6'd50 : sink_mag[5:0];
    freq_sink = vtc_pkg::FreqW'(12'd700 - 12'(sink_c) * 12'd4);
    if (freq_sink < 12'd300) begin
      freq_sink = 12'd300;
    end

    elapsed  = now_ms_i - last_change_q;
    freq_sel = is_sink ? freq_sink : freq_climb;

    priority if (is_dead) begin
      action = ActStop;
    end else if (is_climb && !beep_active_q && elapsed >= 32'(pause_ms)) begin
      action = ActStart;
    end else if (is_climb && beep_active_q && elapsed >= 32'(beep_ms)) begin
      action = ActStop;
    end else if (is_sink) begin
      action = ActStart;
    end else begin
      action = ActNone;
    end
  end

  // ------------------------------------------------------------- sequencer
  vtc_pkg::div_req_t              div_req_q;
  vtc_pkg::div_rsp_t              div_rsp;

  logic [vtc_pkg::FreqW-1:0]      freq_q;
  logic [vtc_pkg::DivisorW-1:0]   prod_q;
  logic [vtc_pkg::TimW-1:0]       presc_q;
  logic                           res_tone_q;
  logic                           res_write_q;
  logic [vtc_pkg::TimW-1:0]       res_presc_q;
  logic [vtc_pkg::TimW-1:0]       res_reload_q;
  logic [vtc_pkg::TimW-1:0]       res_compare_q;
  logic                           out_valid_q;
  logic [vtc_pkg::TimW-1:0]       out_presc_q;
  logic [vtc_pkg::TimW-1:0]       out_reload_q;
  logic [vtc_pkg::TimW-1:0]       out_compare_q;
  logic                           out_tone_q;
  logic                           out_write_q;

  logic                           in_take;
  logic                           fits;
  logic [vtc_pkg::ClkW-1:0]       period_m1;

  assign in_stall_o = (state_q != StIdle);
  assign in_take    = in_valid_i && !in_stall_o;
  // clk / prod <= 0xFFFF exactly when clk >> 16 < prod
  assign fits       = vtc_pkg::DivisorW'(clk_eff[vtc_pkg::ClkW-1:16]) < prod_q;
  assign period_m1  = div_rsp.quotient - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      beep_active_q  <= 1'b0;
      last_change_q  <= '0;
      div_req_q      <= '0;
      out_valid_q    <= 1'b0;
      freq_q         <= '0;
      prod_q         <= '0;
      presc_q        <= '0;
      res_tone_q     <= 1'b0;
      res_write_q    <= 1'b0;
      res_presc_q    <= '0;
      res_reload_q   <= '0;
      res_compare_q  <= '0;
      out_tone_q     <= 1'b0;
      out_write_q    <= 1'b0;
      out_presc_q    <= '0;
      out_reload_q   <= '0;
      out_compare_q  <= '0;
    end else begin
      div_req_q.start <= (state_q == StSearch) && (fits || presc_q == vtc_pkg::PrescLast);
      if (out_valid_q && !out_stall_i && state_q != StFinish) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_take) begin
            res_presc_q   <= '0;
            res_reload_q  <= '0;
            res_compare_q <= '0;
            freq_q        <= freq_sel;
            prod_q        <= vtc_pkg::DivisorW'(freq_sel);
            presc_q       <= '0;
            unique case (action)
              ActStart: begin
                res_tone_q    <= 1'b1;
                res_write_q   <= 1'b1;
                beep_active_q <= 1'b1;
                if (is_climb) begin
                  last_change_q <= now_ms_i;
                end
                state_q <= StSearch;
              end
              ActStop: begin
                res_tone_q    <= 1'b0;
                res_write_q   <= 1'b1;
                beep_active_q <= 1'b0;
                if (is_climb) begin
                  last_change_q <= now_ms_i;
                end
                state_q <= StFinish;
              end
              default: begin
                res_tone_q  <= beep_active_q;
                res_write_q <= 1'b0;
                state_q     <= StFinish;
              end
            endcase
          end
        end
        StSearch: begin
          // advance the prescaler until the period fits in 16 bits or the prescaler reaches its last value
          if (fits || presc_q == vtc_pkg::PrescLast) begin
            div_req_q.dividend <= clk_eff;
            div_req_q.divisor  <= prod_q;
            res_presc_q        <= fits ? presc_q : vtc_pkg::PrescCap;
            state_q            <= StDivide;
          end else begin
            presc_q <= presc_q + 1'b1;
            prod_q  <= prod_q + vtc_pkg::DivisorW'(freq_q);
          end
        end
        StDivide: begin
          if (div_rsp.done) begin
            res_reload_q  <= period_m1[vtc_pkg::TimW-1:0];
            res_compare_q <= period_m1[vtc_pkg::TimW:1];
            state_q       <= StFinish;
          end
        end
        StFinish: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            out_tone_q    <= res_tone_q;
            out_write_q   <= res_write_q;
            out_presc_q   <= res_presc_q;
            out_reload_q  <= res_reload_q;
            out_compare_q <= res_compare_q;
            state_q       <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  vtc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign tone_on_o        = out_tone_q;
  assign timer_write_o    = out_write_q;
  assign prescale_value_o = out_presc_q;
  assign reload_value_o   = out_reload_q;
  assign compare_value_o  = out_compare_q;

`ifndef NO_ASSERTIONS
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(timer_write_o && tone_on_o) |->
      prescale_value_o == '0 && reload_value_o == '0 && compare_value_o == '0)
    else $error("timer fields set without a timer start");
  a_half_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timer_write_o && tone_on_o |->
      compare_value_o == (reload_value_o >> 1) || compare_value_o == 16'hFFFF)
    else $error("compare value is not half of reload");
  a_busy_means_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StSearch || state_q == StDivide |-> beep_active_q)
    else $error("timer search without a start");
  a_div_only_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == StDivide)
    else $error("divider result outside the divide step");
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFinish && (!out_valid_q || !out_stall_i) |=> out_valid_o)
    else $error("finished word not loaded into output");
`endif

endmodule
